>>> rtl/ltrie_pkg.sv
// ----------------------------------------------------------------------------
// ltrie_pkg: shared types and constants of the letter trie
// Operation codes, default sizes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ltrie_pkg;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   localparam int OP_W     = 2;
   localparam int LETTER_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

   typedef struct packed {
      logic clear;
      logic accept;
      logic walk;
      logic mark;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic item_last;
      logic item_search;
   } status_type;

endpackage

>>> rtl/ltrie_dpath.sv
// ----------------------------------------------------------------------------
// ltrie_dpath: trie datapath
// Child table and end-mark memories, word walk state, node allocation,
// clearing pass counter and the result payload register.
// ----------------------------------------------------------------------------
module ltrie_dpath #(
   parameter int NODE_COUNT    = ltrie_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ltrie_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ltrie_pkg::cmd_type                cmd,
   output ltrie_pkg::status_type             status,
   input  logic [ltrie_pkg::OP_W-1:0]        req_operation,
   input  logic [ltrie_pkg::LETTER_W-1:0]    req_letter,
   input  logic                              req_no_letter,
   input  logic                              req_last,
   output logic                              rsp_found,
   output logic                              rsp_pool_full
);
   import ltrie_pkg::*;

   localparam int DEPTH    = NODE_COUNT * ALPHABET_SIZE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int NODE_W   = $clog2(NODE_COUNT);
   localparam int FREE_W   = $clog2(NODE_COUNT + 1);
   localparam int LTR_W    = $clog2(ALPHABET_SIZE);

   logic [NODE_W-1:0] child_mem [DEPTH];
   logic              end_mem   [NODE_COUNT];

   logic [OP_W-1:0]   op_ff;
   logic              last_ff;
   logic              no_letter_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [NODE_W-1:0] child_rd_ff;
   logic              mark_rd_ff;

   logic [NODE_W-1:0] node_ff, node_in;
   logic              missed_ff, missed_in;
   logic              exhausted_ff, exhausted_in;
   logic [FREE_W-1:0] next_free_ff, next_free_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              found_ff, found_in;
   logic              full_ff, full_in;

   logic [LTR_W-1:0]  letter_sat;
   logic [ADDR_W-1:0] rd_addr;
   logic              child_ok;
   logic              pool_empty;
   logic              alloc;
   logic [NODE_W-1:0] walk_node;
   logic              walk_missed;
   logic              walk_exh;
   logic              set_end;
   logic              rsp_load;
   logic              child_we;
   logic [ADDR_W-1:0] child_wa;
   logic [NODE_W-1:0] child_wd;
   logic              end_we;
   logic [NODE_W-1:0] end_wa;
   logic              end_wd;

   assign letter_sat = (32'(req_letter) >= ALPHABET_SIZE) ? LTR_W'(ALPHABET_SIZE - 1)
                                                          : LTR_W'(req_letter);
   assign rd_addr    = ADDR_W'(node_ff) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(letter_sat);
   assign child_ok   = (child_rd_ff != '0) &&
                       ({1'b0, child_rd_ff} < (NODE_W + 1)'(NODE_COUNT));
   assign pool_empty = next_free_ff >= FREE_W'(NODE_COUNT);

   always_comb begin
      walk_node   = node_ff;
      walk_missed = missed_ff;
      walk_exh    = exhausted_ff;
      alloc       = 1'b0;
      if (!no_letter_ff && !missed_ff) begin
         if (child_ok) begin
            walk_node = child_rd_ff;
         end else if (op_ff != OP_INSERT) begin
            walk_missed = 1'b1;
         end else if (pool_empty) begin
            walk_missed = 1'b1;
            walk_exh    = 1'b1;
         end else begin
            alloc     = 1'b1;
            walk_node = next_free_ff[NODE_W-1:0];
         end
      end
   end

   assign set_end  = last_ff && (op_ff == OP_INSERT) && !walk_missed;
   assign rsp_load = (cmd.walk && last_ff && (op_ff != OP_SEARCH)) || cmd.mark;

   always_comb begin
      node_in      = node_ff;
      missed_in    = missed_ff;
      exhausted_in = exhausted_ff;
      next_free_in = next_free_ff;
      clr_cnt_in   = clr_cnt_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      if (cmd.clear) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (cmd.walk) begin
         node_in      = walk_node;
         missed_in    = walk_missed;
         exhausted_in = walk_exh;
         if (alloc) begin
            next_free_in = next_free_ff + 1'b1;
         end
         if (last_ff && (op_ff != OP_SEARCH)) begin
            node_in      = '0;
            missed_in    = 1'b0;
            exhausted_in = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  found_in = !walk_missed;
                  full_in  = walk_missed && walk_exh;
               end
               default: begin
                  found_in = !walk_missed;
                  full_in  = 1'b0;
               end
            endcase
         end
      end
      if (cmd.mark) begin
         node_in      = '0;
         missed_in    = 1'b0;
         exhausted_in = 1'b0;
         found_in     = !missed_ff && mark_rd_ff;
         full_in      = 1'b0;
      end
   end

   always_comb begin
      child_we = cmd.clear || (cmd.walk && alloc);
      child_wa = cmd.clear ? clr_cnt_ff : addr_ff;
      child_wd = cmd.clear ? '0 : next_free_ff[NODE_W-1:0];
      if (cmd.clear) begin
         end_we = clr_cnt_ff < ADDR_W'(NODE_COUNT);
         end_wa = clr_cnt_ff[NODE_W-1:0];
         end_wd = 1'b0;
      end else begin
         end_we = cmd.walk && (alloc || set_end);
         end_wa = walk_node;
         end_wd = set_end;
      end
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wa] <= child_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         child_rd_ff <= child_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[end_wa] <= end_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         mark_rd_ff <= end_mem[walk_node];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_operation;
         last_ff      <= req_last;
         no_letter_ff <= req_no_letter;
         addr_ff      <= rd_addr;
      end
      if (rsp_load) begin
         found_ff <= found_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         missed_ff    <= 1'b0;
         exhausted_ff <= 1'b0;
         next_free_ff <= FREE_W'(1);
         clr_cnt_ff   <= '0;
      end else begin
         node_ff      <= node_in;
         missed_ff    <= missed_in;
         exhausted_ff <= exhausted_in;
         next_free_ff <= next_free_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   assign status.clear_done  = clr_cnt_ff == ADDR_W'(DEPTH - 1);
   assign status.item_last   = last_ff;
   assign status.item_search = op_ff == OP_SEARCH;

   assign rsp_found     = found_ff;
   assign rsp_pool_full = full_ff;

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(NODE_COUNT))
      else $error("free node counter past pool size");

   a_alloc_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && alloc) |=> (next_free_ff == $past(next_free_ff) + 1'b1))
      else $error("allocation did not advance free counter");

   a_restart_root: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |=> (node_ff == '0 && !missed_ff && !exhausted_ff))
      else $error("word state not back at root after result");

endmodule

>>> rtl/ltrie_ctrl.sv
// ----------------------------------------------------------------------------
// ltrie_ctrl: trie controller
// Sequences the clearing pass, item accept, walk step and end-mark step, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module ltrie_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ltrie_pkg::status_type status,
   output ltrie_pkg::cmd_type    cmd
);
   import ltrie_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_MARK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;
   logic      need_rsp;

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign need_rsp = status.item_last && !status.item_search;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!(need_rsp && out_busy)) begin
               cmd.walk = 1'b1;
               if (status.item_last && status.item_search) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
               if (need_rsp) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_MARK: begin
            if (!out_busy) begin
               cmd.mark     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_mark_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> ($past(state_ff) == ST_WALK || $past(state_ff) == ST_MARK))
      else $error("end-mark step without a preceding walk");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.walk || cmd.mark))
      else $error("result raised without a walk or mark step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

>>> rtl/letter_trie_insert_search.sv
// ----------------------------------------------------------------------------
// letter_trie_insert_search: prefix trie over a fixed node pool
//
//   port group  direction  carries
//   req_*       in         operation, letter, no_letter, last
//   rsp_*       out        found, pool_full (one per word, on its last item)
//
// An item runs an accept step with child-table read, then a walk/update step.
// The last item of an exact search adds a step for the end-mark memory read.
// After reset a clearing pass over all NODE_COUNT * ALPHABET_SIZE entries (26624
// by default) zeroes the child table; req_stall stays high meanwhile.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits only when it must produce a result of its own.
// ----------------------------------------------------------------------------
module letter_trie_insert_search #(
   parameter int NODE_COUNT    = ltrie_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ltrie_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ltrie_pkg::OP_W-1:0]     req_operation,
   input  logic [ltrie_pkg::LETTER_W-1:0] req_letter,
   input  logic                           req_no_letter,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic                           rsp_pool_full
);
   import ltrie_pkg::*;

   cmd_type    cmd;
   status_type status;

   ltrie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ltrie_dpath #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_operation),
      .req_letter    (req_letter),
      .req_no_letter (req_no_letter),
      .req_last      (req_last),
      .rsp_found     (rsp_found),
      .rsp_pool_full (rsp_pool_full)
   );

endmodule
